/* rtl/pcrp_pkg.sv */
// Shared types, codes and default sizes for the pc range prefetch table.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package pcrp_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned RES_W     = 3;
  localparam int unsigned IDX_OUT_W = 5;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Default sizes.
  localparam int unsigned TABLE_DEPTH_DEF    = 32;
  localparam int unsigned MAX_PAGE_HINTS_DEF = 16;
  // Line count is fixed for the block; keep it a power of two so the line
  // step is a plain shift.
  localparam int unsigned LINE_COUNT_DEF     = 8;

  // Page shift clamp and line step fallback.
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MIN   = 5'd12;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MAX   = 5'd30;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST   = 5'd12;
  localparam logic [DATA_W-1:0]  LINE_FALLBACK_STEP = 64'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [RES_W-1:0] {
    RES_DONE  = 3'd0,
    RES_FULL  = 3'd1,
    RES_MISS  = 3'd2,
    RES_HIT   = 3'd3,
    RES_PAGE  = 3'd4,
    RES_LINE  = 3'd5
  } result_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDRESS_BASE = 2'd0,
    CFG_PAGE_SHIFT   = 2'd1,
    CFG_PAGE_HINTS   = 2'd2,
    CFG_LINE_PF      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] range_start;
    logic [DATA_W-1:0] range_end;
    logic [DATA_W-1:0] lookup_pc;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0]     result_kind;
    logic [DATA_W-1:0]    address;
    logic [IDX_OUT_W-1:0] entry_index;
    logic                 pages_truncated;
    logic                 last;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/pc_range_prefetch_table_unit.sv */
// Top level of the pc range prefetch table: control sequencer, range memory,
// line step divider and config registers. Depends on pcrp_pkg, pcrp_ram, pcrp_div.
`default_nettype none

// Channel   Direction  Handshake                Payload
// --------  ---------  -----------------------  -------------------------------
// in        input      in_valid_i / in_ready_o  in_item_i  (pcrp_pkg::in_item_t)
// out       output     out_valid_o / out_ready_i out_item_o (pcrp_pkg::out_item_t)
// cfg       input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// Insert, clear and unused kinds go through accept, then one result. A lookup
// scans the range memory one entry per cycle (registered read, the compare
// trails the read), sets up the pages in ST_PG_A, ST_PG_B and ST_PG_C, then
// gives its results. The line step is a shift taken during page setup; line
// results follow a load step in ST_LN_WAIT. Reset empties the table; the
// memory itself is never cleared, since only entries below the fill count are
// read. A stalled output holds the sequencer.

module pc_range_prefetch_table_unit #(
  parameter int unsigned TABLE_DEPTH    = pcrp_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_PAGE_HINTS = pcrp_pkg::MAX_PAGE_HINTS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire pcrp_pkg::in_item_t             in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output pcrp_pkg::out_item_t                 out_item_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [pcrp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pcrp_pkg::DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned LINE_COUNT = pcrp_pkg::LINE_COUNT_DEF;
  localparam int unsigned DW   = pcrp_pkg::DATA_W;
  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PCW  = $clog2(MAX_PAGE_HINTS + 1);
  localparam int unsigned LCW  = $clog2(LINE_COUNT + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ONE,
    ST_SCAN,
    ST_PG_A,
    ST_PG_B,
    ST_PG_C,
    ST_HIT,
    ST_PG_EMIT,
    ST_LN_WAIT,
    ST_LN_EMIT
  } state_e;

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [DW-1:0]                    address_base_q;
  logic [pcrp_pkg::SHIFT_W-1:0]     page_shift_q;
  logic                             pg_en_q;
  logic                             ln_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_base_q <= '0;
      page_shift_q   <= pcrp_pkg::PAGE_SHIFT_RST;
      pg_en_q        <= 1'b0;
      ln_en_q        <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcrp_pkg::CFG_ADDRESS_BASE: address_base_q <= cfg_wdata_i;
        pcrp_pkg::CFG_PAGE_SHIFT:   page_shift_q   <= cfg_wdata_i[pcrp_pkg::SHIFT_W-1:0];
        pcrp_pkg::CFG_PAGE_HINTS:   pg_en_q        <= cfg_wdata_i[0];
        pcrp_pkg::CFG_LINE_PF:      ln_en_q        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the page shift into the supported page sizes.
  logic [pcrp_pkg::SHIFT_W-1:0] sh_c;
  logic [DW-1:0]                page_sz;
  logic [DW-1:0]                page_mask;

  always_comb begin
    if (page_shift_q < pcrp_pkg::PAGE_SHIFT_MIN) begin
      sh_c = pcrp_pkg::PAGE_SHIFT_MIN;
    end else if (page_shift_q > pcrp_pkg::PAGE_SHIFT_MAX) begin
      sh_c = pcrp_pkg::PAGE_SHIFT_MAX;
    end else begin
      sh_c = page_shift_q;
    end
  end

  assign page_sz   = DW'(1) << sh_c;
  assign page_mask = ~(page_sz - DW'(1));

  // ---------------------------------------------------------------------
  // Range memory: start in the upper half, end in the lower half
  // ---------------------------------------------------------------------
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [2*DW-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [2*DW-1:0] ram_rdata;

  pcrp_ram #(
    .WIDTH (2 * DW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Line step divider
  // ---------------------------------------------------------------------
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic          div_done;
  logic [DW-1:0] div_quot;

  pcrp_div #(
    .DIVISOR (LINE_COUNT)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  state_e                         state_q, state_d;
  logic [CNTW-1:0]                count_q, count_d;
  logic [CNTW-1:0]                rd_ptr_q, rd_ptr_d;
  logic                           cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]                  cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]                  hit_idx_q, hit_idx_d;
  logic [DW-1:0]                  pc_q, pc_d;
  logic [DW-1:0]                  s_q, s_d;
  logic [DW-1:0]                  e_q, e_d;
  logic [DW-1:0]                  ps_q, ps_d;
  logic [DW-1:0]                  pe_q, pe_d;
  logic [DW-1:0]                  diff_q, diff_d;
  logic                           pg_ok_q, pg_ok_d;
  logic                           pg_go_q, pg_go_d;
  logic                           ln_go_q, ln_go_d;
  logic                           trunc_q, trunc_d;
  logic [PCW-1:0]                 pg_left_q, pg_left_d;
  logic [LCW-1:0]                 ln_left_q, ln_left_d;
  logic [DW-1:0]                  addr_q, addr_d;
  logic [DW-1:0]                  step_q, step_d;
  logic [pcrp_pkg::RES_W-1:0]     one_kind_q, one_kind_d;
  logic [pcrp_pkg::IDX_OUT_W-1:0] one_idx_q, one_idx_d;
  logic                           out_valid_q, out_valid_d;
  pcrp_pkg::out_item_t            out_q, out_d;

  logic          accept;
  logic          slot;
  logic          issue;
  logic [DW-1:0] rd_start;
  logic [DW-1:0] rd_end;
  logic          hit_now;
  logic [DW-1:0] pages;
  logic          line_go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // the output register is free or is being emptied this cycle
  assign slot       = !out_valid_q || out_ready_i;

  assign rd_start = ram_rdata[2*DW-1:DW];
  assign rd_end   = ram_rdata[DW-1:0];
  assign hit_now  = cmp_vld_q && (pc_q >= rd_start) && (pc_q <= rd_end);
  assign issue    = (state_q == ST_SCAN) && !hit_now && (rd_ptr_q < count_q);
  assign pages    = diff_q >> sh_c;
  assign line_go  = ln_en_q && (e_q > s_q);

  // Inserts write at the accept edge; a lookup is only taken in a later
  // cycle, so a read never overlaps a write to the same entry.
  assign ram_we    = accept && (in_item_i.kind == pcrp_pkg::KIND_INSERT)
                     && (count_q < CNTW'(TABLE_DEPTH));
  assign ram_waddr = count_q[AW-1:0];
  assign ram_wdata = {in_item_i.range_start + address_base_q,
                      in_item_i.range_end + address_base_q};
  assign ram_re    = issue;
  assign ram_raddr = rd_ptr_q[AW-1:0];

  assign div_start    = (state_q == ST_PG_A) && line_go;
  assign div_dividend = e_q - s_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_idx_d   = hit_idx_q;
    pc_d        = pc_q;
    s_d         = s_q;
    e_d         = e_q;
    ps_d        = ps_q;
    pe_d        = pe_q;
    diff_d      = diff_q;
    pg_ok_d     = pg_ok_q;
    pg_go_d     = pg_go_q;
    ln_go_d     = ln_go_q;
    trunc_d     = trunc_q;
    pg_left_d   = pg_left_q;
    ln_left_d   = ln_left_q;
    addr_d      = addr_q;
    step_d      = step_q;
    one_kind_d  = one_kind_q;
    one_idx_d   = one_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          one_idx_d  = '0;
          one_kind_d = pcrp_pkg::RES_DONE;
          state_d    = ST_ONE;
          case (in_item_i.kind)
            pcrp_pkg::KIND_INSERT: begin
              if (count_q < CNTW'(TABLE_DEPTH)) begin
                one_idx_d = pcrp_pkg::IDX_OUT_W'(count_q);
                count_d   = count_q + 1'b1;
              end else begin
                one_kind_d = pcrp_pkg::RES_FULL;
              end
            end
            pcrp_pkg::KIND_LOOKUP: begin
              pc_d     = in_item_i.lookup_pc;
              rd_ptr_d = '0;
              state_d  = ST_SCAN;
            end
            pcrp_pkg::KIND_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end

      ST_ONE: begin
        if (slot) begin
          out_valid_d           = 1'b1;
          out_d.result_kind     = one_kind_q;
          out_d.address         = '0;
          out_d.entry_index     = one_idx_q;
          out_d.pages_truncated = 1'b0;
          out_d.last            = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // read one entry a cycle, compare the one read the cycle before
        if (issue) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_ptr_q[AW-1:0];
          rd_ptr_d  = rd_ptr_q + 1'b1;
        end
        if (hit_now) begin
          hit_idx_d = cmp_idx_q;
          s_d       = rd_start;
          e_d       = rd_end;
          state_d   = ST_PG_A;
        end else if (rd_ptr_q >= count_q) begin
          one_kind_d = pcrp_pkg::RES_MISS;
          one_idx_d  = '0;
          state_d    = ST_ONE;
        end
      end

      ST_PG_A: begin
        ps_d    = s_q & page_mask;
        pe_d    = (e_q + page_sz - DW'(1)) & page_mask;
        ln_go_d = line_go;
        state_d = ST_PG_B;
      end

      ST_PG_B: begin
        pg_ok_d = pe_q > ps_q;
        diff_d  = pe_q - ps_q;
        state_d = ST_PG_C;
      end

      ST_PG_C: begin
        trunc_d   = pg_ok_q && (pages > DW'(MAX_PAGE_HINTS));
        pg_left_d = (pages > DW'(MAX_PAGE_HINTS)) ? PCW'(MAX_PAGE_HINTS)
                                                   : pages[PCW-1:0];
        pg_go_d   = pg_en_q && pg_ok_q;
        addr_d    = ps_q;
        state_d   = ST_HIT;
      end

      ST_HIT: begin
        if (slot) begin
          out_valid_d           = 1'b1;
          out_d.result_kind     = pcrp_pkg::RES_HIT;
          out_d.address         = '0;
          out_d.entry_index     = pcrp_pkg::IDX_OUT_W'(hit_idx_q);
          out_d.pages_truncated = 1'b0;
          out_d.last            = !pg_go_q && !ln_go_q;
          if (pg_go_q) begin
            state_d = ST_PG_EMIT;
          end else if (ln_go_q) begin
            state_d = ST_LN_WAIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_PG_EMIT: begin
        if (slot) begin
          out_valid_d           = 1'b1;
          out_d.result_kind     = pcrp_pkg::RES_PAGE;
          out_d.address         = addr_q;
          out_d.entry_index     = pcrp_pkg::IDX_OUT_W'(hit_idx_q);
          out_d.pages_truncated = trunc_q;
          out_d.last            = (pg_left_q == PCW'(1)) && !ln_go_q;
          addr_d                = addr_q + page_sz;
          pg_left_d             = pg_left_q - 1'b1;
          if (pg_left_q == PCW'(1)) begin
            state_d = ln_go_q ? ST_LN_WAIT : ST_IDLE;
          end
        end
      end

      ST_LN_WAIT: begin
        if (div_done) begin
          step_d    = (div_quot == '0) ? pcrp_pkg::LINE_FALLBACK_STEP : div_quot;
          addr_d    = s_q;
          ln_left_d = LCW'(LINE_COUNT);
          state_d   = ST_LN_EMIT;
        end
      end

      ST_LN_EMIT: begin
        if (slot) begin
          out_valid_d           = 1'b1;
          out_d.result_kind     = pcrp_pkg::RES_LINE;
          out_d.address         = addr_q;
          out_d.entry_index     = pcrp_pkg::IDX_OUT_W'(hit_idx_q);
          out_d.pages_truncated = 1'b0;
          out_d.last            = (ln_left_q == LCW'(1));
          addr_d                = addr_q + step_q;
          ln_left_d             = ln_left_q - 1'b1;
          if (ln_left_q == LCW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      hit_idx_q   <= '0;
      pc_q        <= '0;
      s_q         <= '0;
      e_q         <= '0;
      ps_q        <= '0;
      pe_q        <= '0;
      diff_q      <= '0;
      pg_ok_q     <= 1'b0;
      pg_go_q     <= 1'b0;
      ln_go_q     <= 1'b0;
      trunc_q     <= 1'b0;
      pg_left_q   <= '0;
      ln_left_q   <= '0;
      addr_q      <= '0;
      step_q      <= '0;
      one_kind_q  <= pcrp_pkg::RES_DONE;
      one_idx_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      hit_idx_q   <= hit_idx_d;
      pc_q        <= pc_d;
      s_q         <= s_d;
      e_q         <= e_d;
      ps_q        <= ps_d;
      pe_q        <= pe_d;
      diff_q      <= diff_d;
      pg_ok_q     <= pg_ok_d;
      pg_go_q     <= pg_go_d;
      ln_go_q     <= ln_go_d;
      trunc_q     <= trunc_d;
      pg_left_q   <= pg_left_d;
      ln_left_q   <= ln_left_d;
      addr_q      <= addr_d;
      step_q      <= step_d;
      one_kind_q  <= one_kind_d;
      one_idx_q   <= one_idx_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* rtl/pcrp_ram.sv */
// Generic simple dual port RAM: one write port, one read port, registered read.
// Takes the defaults for its parameters from the package.
`default_nettype none

module pcrp_ram #(
  parameter int unsigned WIDTH = 2 * pcrp_pkg::DATA_W,
  parameter int unsigned DEPTH = pcrp_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/pcrp_div.sv */
// Divider of a 64-bit value by the line count, a power of two: one registered
// shift, quotient registered at start, done_o low while busy. Depends on pcrp_pkg for the width.
`default_nettype none

module pcrp_div #(
  parameter int unsigned DIVISOR = pcrp_pkg::LINE_COUNT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [pcrp_pkg::DATA_W-1:0] dividend_i,
  output logic                             done_o,
  output logic      [pcrp_pkg::DATA_W-1:0] quotient_o
);

  localparam int unsigned SHIFT = $clog2(DIVISOR);

  logic                        busy_q;
  logic [pcrp_pkg::DATA_W-1:0] quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      quot_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      quot_q <= dividend_i >> SHIFT;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign done_o     = ~busy_q;
  assign quotient_o = quot_q;

endmodule

`default_nettype wire
